// File: rtl/log_grid_bilinear_rate_lookup_assert.svh
// Assertion macros for the log-grid rate lookup; each expects clk and rst_n in scope.
`ifndef LOG_GRID_BILINEAR_RATE_LOOKUP_ASSERT_SVH
`define LOG_GRID_BILINEAR_RATE_LOOKUP_ASSERT_SVH

// same-cycle implication
`define LGBR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LGBR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/lgbr_pkg.sv
// Shared types and constants of the log-grid rate lookup.
package lgbr_pkg;

    localparam int VAL_W  = 24;
    localparam int IDX_W  = 5;
    localparam int STG_W  = 4;
    localparam int NUM_W  = 64;
    localparam int DEN_W  = 34;
    localparam int CIDX_W = 2;
    localparam int CDAT_W = 6;

    typedef enum logic [1:0] {
        OP_QUERY  = 2'd0,
        OP_WR_DAX = 2'd1,
        OP_WR_TAX = 2'd2,
        OP_WR_TAB = 2'd3
    } opcode_t;

    typedef enum logic [CIDX_W-1:0] {
        CFG_NUM_DENS   = 2'd0,
        CFG_NUM_TEMPS  = 2'd1,
        CFG_NUM_STAGES = 2'd2,
        CFG_UNUSED     = 2'd3
    } cfg_idx_t;

    typedef struct packed {
        logic [5:0] num_densities;
        logic [5:0] num_temperatures;
        logic [4:0] num_stages;
    } cfg_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic [STG_W-1:0]          stage;
        logic [IDX_W-1:0]          density_index;
        logic [IDX_W-1:0]          temperature_index;
        logic signed [VAL_W-1:0]   write_value;
        logic signed [VAL_W-1:0]   query_log_density;
        logic signed [VAL_W-1:0]   query_log_temperature;
    } cmd_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_ENDS0,
        ST_ENDS1,
        ST_ENDS2,
        ST_BSRCH,
        ST_BCMP,
        ST_CELL0,
        ST_CELL1,
        ST_CELL2,
        ST_TRD,
        ST_TCAP,
        ST_MUL,
        ST_ACC,
        ST_DIVS,
        ST_DIVW,
        ST_OUT
    } state_t;

endpackage

// File: rtl/log_grid_bilinear_rate_lookup.sv
// Query flow: a search on each axis (binary unless the key is clamped), four table reads
// and three serial divisions on the 64-step divider, run one after another.
// Writes are done in the idle state; a two-beat queue decouples input from the back end.
// The back end takes no new command until the current query has loaded its result register.
// Reset: sizes return to 2, 2 and 1, queue and result register empty; axis and
// table memories keep their contents and are not cleared.
module log_grid_bilinear_rate_lookup #(
    parameter int MAX_DENSITIES    = 32,
    parameter int MAX_TEMPERATURES = 32,
    parameter int MAX_STAGES       = 16
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [3:0] stage, [8:4] density_index, [13:9] temperature_index, [37:14] write_value,
    // [61:38] query_log_density, [85:62] query_log_temperature, [87:86] zero
    input  logic [87:0]                     s_axis_tdata,
    input  logic [1:0]                      s_axis_tuser,   // [1:0] opcode
    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    output logic [23:0]                     m_axis_tdata,   // [23:0] log_rate
    output logic                            m_axis_tuser,   // [0] status
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [lgbr_pkg::CIDX_W-1:0]     cfg_index,
    input  logic [lgbr_pkg::CDAT_W-1:0]     cfg_data
);
    import lgbr_pkg::*;

    cfg_t cfg_reg;
    logic q_valid;
    cmd_t q_cmd;
    logic q_pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.num_densities    <= 6'd2;
            cfg_reg.num_temperatures <= 6'd2;
            cfg_reg.num_stages       <= 5'd1;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_NUM_DENS:   cfg_reg.num_densities    <= cfg_data;
                CFG_NUM_TEMPS:  cfg_reg.num_temperatures <= cfg_data;
                CFG_NUM_STAGES: cfg_reg.num_stages       <= cfg_data[4:0];
                default: ;
            endcase
        end
    end

    lgbr_front #(
        .MAX_DENSITIES    (MAX_DENSITIES),
        .MAX_TEMPERATURES (MAX_TEMPERATURES),
        .MAX_STAGES       (MAX_STAGES)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop)
    );

    lgbr_back #(
        .MAX_DENSITIES    (MAX_DENSITIES),
        .MAX_TEMPERATURES (MAX_TEMPERATURES),
        .MAX_STAGES       (MAX_STAGES)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg_reg),
        .q_valid       (q_valid),
        .q_cmd         (q_cmd),
        .q_pop         (q_pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

// File: rtl/lgbr_front.sv
// Input side: takes beats, drops out-of-range writes, queues commands for the back end.
module lgbr_front #(
    parameter int MAX_DENSITIES    = 32,
    parameter int MAX_TEMPERATURES = 32,
    parameter int MAX_STAGES       = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [87:0]   s_axis_tdata,
    input  logic [1:0]    s_axis_tuser,
    output logic          q_valid,
    output lgbr_pkg::cmd_t q_cmd,
    input  logic          q_pop
);
    import lgbr_pkg::*;

    cmd_t       in_cmd;
    logic       keep;
    logic       push;
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    cmd_t       buf_reg [2];

    always_comb
    begin
        in_cmd.opcode                = opcode_t'(s_axis_tuser);
        in_cmd.stage                 = s_axis_tdata[3:0];
        in_cmd.density_index         = s_axis_tdata[8:4];
        in_cmd.temperature_index     = s_axis_tdata[13:9];
        in_cmd.write_value           = $signed(s_axis_tdata[37:14]);
        in_cmd.query_log_density     = $signed(s_axis_tdata[61:38]);
        in_cmd.query_log_temperature = $signed(s_axis_tdata[85:62]);
    end

    always_comb
    begin
        unique case (in_cmd.opcode)
            OP_QUERY:  keep = 1'b1;
            OP_WR_DAX: keep = (int'(in_cmd.density_index) < MAX_DENSITIES);
            OP_WR_TAX: keep = (int'(in_cmd.temperature_index) < MAX_TEMPERATURES);
            OP_WR_TAB: keep = (int'(in_cmd.stage) < MAX_STAGES)
                           && (int'(in_cmd.temperature_index) < MAX_TEMPERATURES)
                           && (int'(in_cmd.density_index) < MAX_DENSITIES);
            default:   keep = 1'b0;
        endcase
    end

    assign s_axis_tready = (cnt_reg != 2'd2);
    assign push          = s_axis_tvalid && s_axis_tready && keep;
    assign q_valid       = (cnt_reg != 2'd0);
    assign q_cmd         = buf_reg[rp_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !(q_pop && q_valid))
            cnt_next = cnt_reg + 2'd1;
        else if (!push && q_pop && q_valid)
            cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (push)
                wp_reg <= ~wp_reg;
            if (q_pop && q_valid)
                rp_reg <= ~rp_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            buf_reg[wp_reg] <= in_cmd;
    end

endmodule

// File: rtl/lgbr_div.sv
// Serial divider, one quotient bit a cycle: floor((2*num + den) / (2*den)), den > 0.
module lgbr_div (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                start,
    input  logic signed [lgbr_pkg::NUM_W-1:0]   num,
    input  logic [lgbr_pkg::DEN_W-1:0]          den,
    output logic                                done,
    output logic signed [lgbr_pkg::NUM_W-1:0]   quot
);
    import lgbr_pkg::*;

    localparam int CW = $clog2(NUM_W);

    logic signed [NUM_W-1:0] n_start;
    logic [NUM_W-1:0]        mag_start;
    logic                    busy_reg;
    logic                    done_reg;
    logic [CW-1:0]           cnt_reg;
    logic [NUM_W-1:0]        work_reg;
    logic [DEN_W:0]          rem_reg;
    logic [DEN_W:0]          d_reg;
    logic                    neg_reg;
    logic [DEN_W+1:0]        rem_sh;
    logic                    ge;
    logic [DEN_W+1:0]        rem_sub;

    assign n_start   = (num <<< 1) + $signed(NUM_W'(den));
    assign mag_start = n_start[NUM_W-1] ? NUM_W'(-n_start) : NUM_W'(n_start);

    assign rem_sh  = {rem_reg, work_reg[NUM_W-1]};
    assign ge      = (rem_sh >= {1'b0, d_reg});
    assign rem_sub = rem_sh - {1'b0, d_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CW'(1);
                if (cnt_reg == CW'(NUM_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            work_reg <= mag_start;
            rem_reg  <= '0;
            d_reg    <= {den, 1'b0};
            neg_reg  <= n_start[NUM_W-1];
        end
        else if (busy_reg)
        begin
            work_reg <= {work_reg[NUM_W-2:0], ge};
            rem_reg  <= ge ? rem_sub[DEN_W:0] : rem_sh[DEN_W:0];
        end
    end

    // floor for negative numerators: round the magnitude quotient up
    assign quot = neg_reg ? -$signed(work_reg + NUM_W'(rem_reg != '0)) : $signed(work_reg);
    assign done = done_reg;

endmodule

// File: rtl/lgbr_back.sv
// Back end: axis and table memories, both searches, interpolation sequencer, result register.
module lgbr_back #(
    parameter int MAX_DENSITIES    = 32,
    parameter int MAX_TEMPERATURES = 32,
    parameter int MAX_STAGES       = 16
) (
    input  logic            clk,
    input  logic            rst_n,
    input  lgbr_pkg::cfg_t  cfg,
    input  logic            q_valid,
    input  lgbr_pkg::cmd_t  q_cmd,
    output logic            q_pop,
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [23:0]     m_axis_tdata,   // [23:0] log_rate
    output logic            m_axis_tuser    // [0] status
);
    import lgbr_pkg::*;

    localparam int DAW    = $clog2(MAX_DENSITIES);
    localparam int TAW    = $clog2(MAX_TEMPERATURES);
    localparam int SW     = (MAX_STAGES > 1) ? $clog2(MAX_STAGES) : 1;
    localparam int XW     = (DAW > TAW) ? DAW : TAW;
    localparam int TABW   = SW + TAW + DAW;
    localparam int DIFF_W = VAL_W + 1;
    localparam int OPA_W  = 32;
    localparam int OPB_W  = DIFF_W + 1;
    localparam int PROD_W = OPA_W + OPB_W;
    localparam int ACC_W  = PROD_W + 2;

    logic signed [VAL_W-1:0] dax_mem [MAX_DENSITIES];
    logic signed [VAL_W-1:0] tax_mem [MAX_TEMPERATURES];
    logic signed [VAL_W-1:0] tab_mem [2**TABW];

    state_t state_reg, state_next;

    cmd_t                     cmd_reg;
    logic                     sel_reg;
    logic                     fail_reg;
    logic [XW-1:0]            lo_reg, hi_reg, mid_reg;
    logic signed [VAL_W-1:0]  ax_q, ax0_reg, axa_reg, key_reg, tab_q;
    logic [DAW-1:0]           a_reg;
    logic [TAW-1:0]           b_reg;
    logic signed [DIFF_W-1:0] dx_reg, dy_reg, x2x_reg, xx1_reg, y2y_reg, yy1_reg;
    logic signed [VAL_W-1:0]  r_reg [4];
    logic [1:0]               tcnt_reg;
    logic [2:0]               mstep_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [31:0]       g0_reg, g1_reg;
    logic signed [VAL_W-1:0]  res_reg;
    logic                     m_valid_reg;
    logic signed [VAL_W-1:0]  m_rate_reg;
    logic                     m_status_reg;

    logic [5:0]               n_axis, nm1;
    logic [XW-1:0]            nm1_x, mid, raddr;
    logic [TABW-1:0]          taddr;
    logic signed [VAL_W-1:0]  key_in;
    logic                     below, at_top;
    logic signed [DIFF_W-1:0] cell_d, cell_up, cell_lo;
    logic                     bad_cfg;
    logic signed [OPA_W-1:0]  opa;
    logic signed [OPB_W-1:0]  opb;
    logic signed [PROD_W-1:0] prod;
    logic signed [NUM_W-1:0]  div_num, div_quot;
    logic [DEN_W-1:0]         div_den;
    logic                     div_start, div_done;
    logic signed [31:0]       g_sat;
    logic signed [VAL_W-1:0]  r_sat;
    logic                     out_load;

    // ---------------- datapath combinational ----------------
    assign n_axis = sel_reg ? cfg.num_temperatures : cfg.num_densities;
    assign nm1    = n_axis - 6'd1;
    assign nm1_x  = XW'(nm1);
    assign mid    = lo_reg + ((hi_reg - lo_reg) >> 1);
    assign key_in = sel_reg ? cmd_reg.query_log_temperature : cmd_reg.query_log_density;
    assign below  = (key_in < ax0_reg);
    assign at_top = (key_in >= ax_q);
    assign cell_d  = DIFF_W'(ax_q) - DIFF_W'(axa_reg);
    assign cell_up = DIFF_W'(ax_q) - DIFF_W'(key_reg);
    assign cell_lo = DIFF_W'(key_reg) - DIFF_W'(axa_reg);

    assign bad_cfg = (cfg.num_densities < 6'd2) || (int'(cfg.num_densities) > MAX_DENSITIES)
                  || (cfg.num_temperatures < 6'd2)
                  || (int'(cfg.num_temperatures) > MAX_TEMPERATURES)
                  || ({1'b0, q_cmd.stage} >= cfg.num_stages)
                  || (int'(q_cmd.stage) >= MAX_STAGES);

    assign taddr = {SW'(cmd_reg.stage), b_reg + TAW'(tcnt_reg[1]), a_reg + DAW'(tcnt_reg[0])};

    always_comb
    begin
        case (mstep_reg)
            3'd0:    begin opa = OPA_W'(r_reg[0]); opb = OPB_W'(x2x_reg); end
            3'd1:    begin opa = OPA_W'(r_reg[1]); opb = OPB_W'(xx1_reg); end
            3'd2:    begin opa = OPA_W'(r_reg[2]); opb = OPB_W'(x2x_reg); end
            3'd3:    begin opa = OPA_W'(r_reg[3]); opb = OPB_W'(xx1_reg); end
            3'd4:    begin opa = g0_reg;           opb = OPB_W'(y2y_reg); end
            default: begin opa = g1_reg;           opb = OPB_W'(yy1_reg); end
        endcase
    end

    assign prod = opa * opb;

    // row passes carry 8 extra fraction bits; the column pass takes them back out
    always_comb
    begin
        if (mstep_reg == 3'd5)
        begin
            div_num = NUM_W'(acc_reg);
            div_den = DEN_W'({$unsigned(dy_reg), 8'h00});
        end
        else
        begin
            div_num = NUM_W'(acc_reg) <<< 8;
            div_den = DEN_W'($unsigned(dx_reg));
        end
    end

    always_comb
    begin
        if (div_quot > 64'sd2147483647)
            g_sat = 32'sh7fffffff;
        else if (div_quot < -64'sd2147483648)
            g_sat = 32'sh80000000;
        else
            g_sat = div_quot[31:0];
        if (div_quot > 64'sd8388607)
            r_sat = 24'sh7fffff;
        else if (div_quot < -64'sd8388608)
            r_sat = 24'sh800000;
        else
            r_sat = div_quot[VAL_W-1:0];
    end

    lgbr_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .start (div_start),
        .num   (div_num),
        .den   (div_den),
        .done  (div_done),
        .quot  (div_quot)
    );

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
                if (q_valid && q_cmd.opcode == OP_QUERY)
                    state_next = bad_cfg ? ST_OUT : ST_ENDS0;
            ST_ENDS0: state_next = ST_ENDS1;
            ST_ENDS1: state_next = ST_ENDS2;
            ST_ENDS2: state_next = (below || at_top) ? ST_CELL0 : ST_BSRCH;
            ST_BSRCH: state_next = ((hi_reg - lo_reg) > XW'(1)) ? ST_BCMP : ST_CELL0;
            ST_BCMP:  state_next = ST_BSRCH;
            ST_CELL0: state_next = ST_CELL1;
            ST_CELL1: state_next = ST_CELL2;
            ST_CELL2:
                if (cell_d <= 0)
                    state_next = ST_OUT;
                else
                    state_next = sel_reg ? ST_TRD : ST_ENDS0;
            ST_TRD:   state_next = ST_TCAP;
            ST_TCAP:  state_next = (tcnt_reg == 2'd3) ? ST_MUL : ST_TRD;
            ST_MUL:   state_next = ST_ACC;
            ST_ACC:   state_next = mstep_reg[0] ? ST_DIVS : ST_MUL;
            ST_DIVS:  state_next = ST_DIVW;
            ST_DIVW:
                if (div_done)
                    state_next = (mstep_reg == 3'd5) ? ST_OUT : ST_MUL;
            ST_OUT:
                if (out_load)
                    state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    // ---------------- control outputs ----------------
    always_comb
    begin
        q_pop     = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        raddr     = '0;
        unique case (state_reg)
            ST_IDLE:  q_pop = q_valid;
            ST_ENDS0: raddr = '0;
            ST_ENDS1: raddr = nm1_x;
            ST_BSRCH: raddr = mid;
            ST_CELL0: raddr = lo_reg;
            ST_CELL1: raddr = lo_reg + XW'(1);
            ST_DIVS:  div_start = 1'b1;
            ST_OUT:   out_load = !m_valid_reg || m_axis_tready;
            default:  raddr = '0;
        endcase
    end

    // ---------------- memories ----------------
    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.opcode == OP_WR_DAX)
            dax_mem[DAW'(q_cmd.density_index)] <= q_cmd.write_value;
        ax_q <= sel_reg ? tax_mem[raddr[TAW-1:0]] : dax_mem[raddr[DAW-1:0]];
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.opcode == OP_WR_TAX)
            tax_mem[TAW'(q_cmd.temperature_index)] <= q_cmd.write_value;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && q_cmd.opcode == OP_WR_TAB)
            tab_mem[{SW'(q_cmd.stage), TAW'(q_cmd.temperature_index),
                     DAW'(q_cmd.density_index)}] <= q_cmd.write_value;
        tab_q <= tab_mem[taddr];
    end

    // ---------------- control registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                m_valid_reg <= 1'b1;
            else if (m_axis_tready)
                m_valid_reg <= 1'b0;
        end
    end

    // ---------------- datapath registers ----------------
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                cmd_reg   <= q_cmd;
                sel_reg   <= 1'b0;
                fail_reg  <= bad_cfg;
                tcnt_reg  <= 2'd0;
                mstep_reg <= 3'd0;
            end
            ST_ENDS1: ax0_reg <= ax_q;
            ST_ENDS2:
            begin
                // clamp the key into the axis
                if (below)
                begin
                    key_reg <= ax0_reg;
                    lo_reg  <= '0;
                end
                else if (at_top)
                begin
                    key_reg <= ax_q;
                    lo_reg  <= nm1_x - XW'(1);
                end
                else
                begin
                    key_reg <= key_in;
                    lo_reg  <= '0;
                    hi_reg  <= nm1_x;
                end
            end
            ST_BSRCH: mid_reg <= mid;
            ST_BCMP:
            begin
                if (key_reg < ax_q)
                    hi_reg <= mid_reg;
                else
                    lo_reg <= mid_reg;
            end
            ST_CELL1: axa_reg <= ax_q;
            ST_CELL2:
            begin
                fail_reg <= (cell_d <= 0);
                sel_reg  <= 1'b1;
                if (!sel_reg)
                begin
                    a_reg   <= DAW'(lo_reg);
                    dx_reg  <= cell_d;
                    x2x_reg <= cell_up;
                    xx1_reg <= cell_lo;
                end
                else
                begin
                    b_reg   <= TAW'(lo_reg);
                    dy_reg  <= cell_d;
                    y2y_reg <= cell_up;
                    yy1_reg <= cell_lo;
                end
            end
            ST_TCAP:
            begin
                r_reg[tcnt_reg] <= tab_q;
                tcnt_reg        <= tcnt_reg + 2'd1;
            end
            ST_MUL: prod_reg <= prod;
            ST_ACC:
            begin
                acc_reg <= mstep_reg[0] ? acc_reg + ACC_W'(prod_reg) : ACC_W'(prod_reg);
                if (!mstep_reg[0])
                    mstep_reg <= mstep_reg + 3'd1;
            end
            ST_DIVW:
            begin
                if (div_done)
                begin
                    case (mstep_reg)
                        3'd1:    g0_reg  <= g_sat;
                        3'd3:    g1_reg  <= g_sat;
                        default: res_reg <= r_sat;
                    endcase
                    mstep_reg <= mstep_reg + 3'd1;
                end
            end
            ST_OUT:
            begin
                if (out_load)
                begin
                    m_rate_reg   <= fail_reg ? '0 : res_reg;
                    m_status_reg <= fail_reg;
                end
            end
            default: ;
        endcase
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_rate_reg;
    assign m_axis_tuser  = m_status_reg;

    `include "log_grid_bilinear_rate_lookup_assert.svh"

    `LGBR_ASSERT_IMP(a_idle_takes, (state_reg == ST_IDLE) && q_valid, q_pop, "idle back end left a queued command")
    `LGBR_ASSERT_IMP(a_fail_zero, m_valid_reg && m_status_reg, m_rate_reg == '0, "unavailable result carries a nonzero rate")
    `LGBR_ASSERT_NXT(a_div_wait, div_start, state_reg == ST_DIVW, "division started without waiting")
    `LGBR_ASSERT_IMP(a_done_seen, div_done, state_reg == ST_DIVW, "division finished outside its wait state")

endmodule

// File: tb/tb.sv
// Self-checking testbench for the log-grid bilinear rate lookup.
`timescale 1ns / 1ps

module tb;
    import lgbr_pkg::*;

    typedef struct {
        logic [23:0] rate;
        logic        status;
    } rate_res_t;

    typedef struct {
        cmd_t        c;
        bit          typed;
        logic [23:0] rate;
        logic        status;
    } stim_row_t;

    typedef int axis_t[32];

    logic         clk;
    logic         rst_n;
    logic         s_axis_tvalid;
    logic         s_axis_tready;
    logic [87:0]  s_axis_tdata;
    logic [1:0]   s_axis_tuser;
    logic         m_axis_tvalid;
    logic         m_axis_tready;
    logic [23:0]  m_axis_tdata;
    logic         m_axis_tuser;
    logic         cfg_valid;
    logic         cfg_ready;
    logic [CIDX_W-1:0] cfg_index;
    logic [CDAT_W-1:0] cfg_data;

    // shadow of the block's state
    axis_t        dens_axis;
    axis_t        temp_axis;
    int           rate_mem[16384];
    logic [5:0]   n_dens;
    logic [5:0]   n_temps;
    logic [4:0]   n_stages;

    rate_res_t    pending_rates[$];
    int           errors;
    int           send_idle;
    int           recv_idle;
    stim_row_t    rows[$];

    log_grid_bilinear_rate_lookup dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        #8ms;
        $display("Regression FAIL");
        $finish;
    end

    function automatic longint round_div(longint num, longint den);
        longint n;
        longint d;
        longint q;
        n = 2 * num + den;
        d = 2 * den;
        q = n / d;
        if ((n % d) != 0 && n < 0)
            q = q - 1;
        return q;
    endfunction

    function automatic longint clip(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    // clamps key into the axis, returns lower cell index
    function automatic int find_cell(axis_t ax, int n, inout int key);
        int lo;
        int hi;
        int mid;
        lo = 0;
        hi = n - 1;
        if (key < ax[0])
        begin
            key = ax[0];
            return 0;
        end
        if (key > ax[n-1])
        begin
            key = ax[n-1];
            return n - 2;
        end
        if (key == ax[n-1])
            return n - 2;
        while (hi - lo > 1)
        begin
            mid = lo + (hi - lo) / 2;
            if (key < ax[mid])
                hi = mid;
            else
                lo = mid;
        end
        return lo;
    endfunction

    function automatic int rate_addr(int s, int t, int d);
        return (s * 32 + t) * 32 + d;
    endfunction

    // updates the shadow state; returns 1 when the beat yields a result
    function automatic bit interpolate_rate(cmd_t c, output rate_res_t r);
        int     kx;
        int     ky;
        int     a;
        int     b;
        int     s;
        longint dx;
        longint dy;
        longint g0;
        longint g1;
        longint v;
        r.rate   = '0;
        r.status = 1'b1;
        case (c.opcode)
            OP_WR_DAX:
            begin
                dens_axis[c.density_index] = int'(c.write_value);
                return 1'b0;
            end
            OP_WR_TAX:
            begin
                temp_axis[c.temperature_index] = int'(c.write_value);
                return 1'b0;
            end
            OP_WR_TAB:
            begin
                rate_mem[rate_addr(c.stage, c.temperature_index, c.density_index)] =
                    int'(c.write_value);
                return 1'b0;
            end
            default:
            begin
            end
        endcase
        if (n_dens < 2 || n_dens > 32 || n_temps < 2 || n_temps > 32)
            return 1'b1;
        if (c.stage >= n_stages)
            return 1'b1;
        s  = c.stage;
        kx = int'(c.query_log_density);
        ky = int'(c.query_log_temperature);
        a  = find_cell(dens_axis, n_dens, kx);
        b  = find_cell(temp_axis, n_temps, ky);
        dx = longint'(dens_axis[a+1]) - dens_axis[a];
        dy = longint'(temp_axis[b+1]) - temp_axis[b];
        if (dx <= 0 || dy <= 0)
            return 1'b1;
        g0 = round_div((longint'(rate_mem[rate_addr(s, b, a)]) * (dens_axis[a+1] - kx) +
                        longint'(rate_mem[rate_addr(s, b, a+1)]) * (kx - dens_axis[a]))
                       * 256, dx);
        g1 = round_div((longint'(rate_mem[rate_addr(s, b+1, a)]) * (dens_axis[a+1] - kx) +
                        longint'(rate_mem[rate_addr(s, b+1, a+1)]) * (kx - dens_axis[a]))
                       * 256, dx);
        g0 = clip(g0, -64'sd2147483648, 64'sd2147483647);
        g1 = clip(g1, -64'sd2147483648, 64'sd2147483647);
        v  = round_div(g0 * (longint'(temp_axis[b+1]) - ky) +
                       g1 * (longint'(ky) - temp_axis[b]), dy * 256);
        v  = clip(v, -64'sd8388608, 64'sd8388607);
        r.rate   = v[23:0];
        r.status = 1'b0;
        return 1'b1;
    endfunction

    function automatic cmd_t mk_cmd(opcode_t op, int st, int di, int ti, int wv,
                                    int kx, int ky);
        cmd_t c;
        c.opcode                = op;
        c.stage                 = st[3:0];
        c.density_index         = di[4:0];
        c.temperature_index     = ti[4:0];
        c.write_value           = wv[23:0];
        c.query_log_density     = kx[23:0];
        c.query_log_temperature = ky[23:0];
        return c;
    endfunction

    task automatic add_row(cmd_t c, bit typed = 1'b0, int er = 0, bit es = 1'b0);
        stim_row_t r;
        r.c      = c;
        r.typed  = typed;
        r.rate   = er[23:0];
        r.status = es;
        rows.push_back(r);
    endtask

    task automatic send_cmd(cmd_t c, bit typed = 1'b0, logic [23:0] er = '0,
                            logic es = 1'b0);
        rate_res_t r;
        if ($urandom_range(99) < send_idle)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < send_idle)
                @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {2'b00, c.query_log_temperature, c.query_log_density,
                          c.write_value, c.temperature_index, c.density_index, c.stage};
        s_axis_tuser  <= c.opcode;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        if (interpolate_rate(c, r))
        begin
            if (typed)
            begin
                r.rate   = er;
                r.status = es;
            end
            pending_rates.push_back(r);
        end
    endtask

    task automatic drain_results();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_rates.size() != 0)
            @(posedge clk);
        // writes still in flight produce no result
        repeat (400) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val[CDAT_W-1:0];
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        cfg_valid <= 1'b0;
        @(posedge clk);
        case (idx)
            CFG_NUM_DENS:   n_dens   = val[5:0];
            CFG_NUM_TEMPS:  n_temps  = val[5:0];
            CFG_NUM_STAGES: n_stages = val[4:0];
            default:
            begin
            end
        endcase
    endtask

    // ascending axis with the odd flat or reversed step; only the points in use
    task automatic load_axis(opcode_t op, int n);
        int v;
        int i;
        int k;
        int m;
        m = (n < 2 || n > 32) ? 2 : n;
        v = -4194304 + int'($urandom_range(4194304));
        for (i = 0; i < m; i++)
        begin
            send_cmd(mk_cmd(op, $urandom_range(15), i, i, v, $urandom, $urandom));
            k = $urandom_range(99);
            if (k < 3)
                v = v - int'($urandom_range(1000));
            else if (k >= 6)
                v = v + 1 + int'($urandom_range(131071));
        end
    endtask

    function automatic int pick_key(axis_t ax, int n);
        int m;
        int k;
        m = (n < 2 || n > 32) ? 1 : n - 1;
        k = $urandom_range(9);
        if (k < 5)
            return ax[0] + int'($urandom_range(ax[m] > ax[0] ? ax[m] - ax[0] : 0));
        if (k < 7)
            return ax[$urandom_range(m)];
        if (k == 7)
            return ax[0] - int'($urandom_range(100000));
        if (k == 8)
            return ax[m] + int'($urandom_range(100000));
        return int'({{8{1'b0}}, 24'($urandom)} ^ 32'h0080_0000) - 8388608;
    endfunction

    task automatic run_phase(int nd, int nt, int ns, int count);
        int     i;
        int     k;
        drain_results();
        write_reg(CFG_NUM_DENS, nd);
        write_reg(CFG_NUM_TEMPS, nt);
        write_reg(CFG_NUM_STAGES, ns);
        load_axis(OP_WR_DAX, nd);
        load_axis(OP_WR_TAX, nt);
        for (i = 0; i < count; i++)
        begin
            k = $urandom_range(99);
            if (k < 75)
                send_cmd(mk_cmd(OP_QUERY,
                                ($urandom_range(3) == 0) ? $urandom_range(15)
                                    : $urandom_range(ns > 0 ? (ns > 16 ? 15 : ns - 1) : 0),
                                $urandom, $urandom, $urandom,
                                pick_key(dens_axis, nd), pick_key(temp_axis, nt)));
            else if (k < 93)
                send_cmd(mk_cmd(OP_WR_TAB, $urandom_range(15), $urandom_range(31),
                                $urandom_range(31), $urandom, $urandom, $urandom));
            else if (k < 96)
                send_cmd(mk_cmd(OP_WR_DAX, $urandom, $urandom_range(31), $urandom,
                                $urandom, $urandom, $urandom));
            else
                send_cmd(mk_cmd(OP_WR_TAX, $urandom, $urandom, $urandom_range(31),
                                $urandom, $urandom, $urandom));
        end
    endtask

    // result side: random back-pressure and in-order check
    always @(posedge clk or negedge rst_n)
    begin
        rate_res_t want;
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle);
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_rates.size() == 0)
                begin
                    $error("unexpected result beat: log_rate %h status %b",
                           m_axis_tdata, m_axis_tuser);
                    errors++;
                end
                else
                begin
                    want = pending_rates.pop_front();
                    if (m_axis_tdata !== want.rate)
                    begin
                        $error("log_rate: expected %h, got %h", want.rate, m_axis_tdata);
                        errors++;
                    end
                    if (m_axis_tuser !== want.status)
                    begin
                        $error("status: expected %b, got %b", want.status, m_axis_tuser);
                        errors++;
                    end
                end
            end
        end
    end

    initial
    begin
        int i;
        int s;
        int t;
        int d;
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = '0;
        cfg_valid     = 1'b0;
        cfg_index     = CFG_NUM_DENS;
        cfg_data      = '0;
        errors        = 0;
        n_dens        = 6'd2;
        n_temps       = 6'd2;
        n_stages      = 5'd1;
        send_idle     = 8;
        recv_idle     = 55;
        foreach (rate_mem[j])
            rate_mem[j] = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: bad stage, corners, clamping, flat and reversed cells
        add_row(mk_cmd(OP_QUERY, 1, 0, 0, 0, 0, 0), 1'b1, 0, 1'b1);
        add_row(mk_cmd(OP_QUERY, 15, 31, 31, 0, 0, 0), 1'b1, 0, 1'b1);
        add_row(mk_cmd(OP_WR_DAX, 0, 0, 0, -8388608, 0, 0));
        add_row(mk_cmd(OP_WR_DAX, 0, 1, 0, 8388607, 0, 0));
        add_row(mk_cmd(OP_WR_TAX, 0, 0, 0, 0, 0, 0));
        add_row(mk_cmd(OP_WR_TAX, 0, 0, 1, 32'h10000, 0, 0));
        add_row(mk_cmd(OP_WR_TAB, 0, 0, 0, -8388608, 0, 0));
        add_row(mk_cmd(OP_WR_TAB, 0, 1, 0, 8388607, 0, 0));
        add_row(mk_cmd(OP_WR_TAB, 0, 0, 1, 0, 0, 0));
        add_row(mk_cmd(OP_WR_TAB, 0, 1, 1, 32'h100000, 0, 0));
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, -8388608, 0), 1'b1, -8388608, 1'b0);
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, 8388607, 32'h10000), 1'b1, 32'h100000, 1'b0);
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, 0, 32'h8000));
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, -8388608, -8388608), 1'b1, -8388608, 1'b0);
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, -8388608, 8388607), 1'b1, 0, 1'b0);
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, 12345, -77));
        add_row(mk_cmd(OP_WR_TAX, 0, 0, 1, 0, 0, 0));
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, 5, 0), 1'b1, 0, 1'b1);
        add_row(mk_cmd(OP_WR_TAX, 0, 0, 1, -5, 0, 0));
        add_row(mk_cmd(OP_QUERY, 0, 0, 0, 0, 5, 0), 1'b1, 0, 1'b1);
        add_row(mk_cmd(OP_WR_TAX, 0, 0, 1, 32'h10000, 0, 0));
        add_row(mk_cmd(OP_QUERY, 0, 31, 31, -1, 8388607, 8388607));
        add_row(mk_cmd(OP_WR_TAB, 15, 31, 31, 8388607, -1, -1));
        for (i = 0; i < rows.size(); i++)
            send_cmd(rows[i].c, rows[i].typed, rows[i].rate, rows[i].status);

        // fill the table entries that the phases below can reach: stages 0 and 1
        // up to 8 by 8, and stage 0 along full-length rows and columns
        for (s = 0; s < 2; s++)
            for (t = 0; t < 32; t++)
                for (d = 0; d < 32; d++)
                    if ((t < 8 && d < 8) || (s == 0 && (t < 2 || d < 2)))
                        send_cmd(mk_cmd(OP_WR_TAB, s, d, t,
                                        ($urandom_range(15) == 0) ?
                                            (($urandom_range(1) == 1) ? 8388607 : -8388608)
                                            : int'($urandom),
                                        0, 0));

        drain_results();
        write_reg(CFG_UNUSED, 6'h3f);   // ignored index
        run_phase(32, 2, 1, 50);
        run_phase(2, 32, 1, 50);
        run_phase(5, 7, 2, 50);
        send_idle = 55;
        recv_idle = 8;
        run_phase(33, 2, 16, 25);
        run_phase(8, 8, 2, 60);
        run_phase(0, 1, 0, 25);
        send_idle = 0;
        recv_idle = 0;
        run_phase(2, 2, 1, 60);
        run_phase(63, 63, 8, 20);
        run_phase(6, 8, 2, 60);

        drain_results();
        if (errors == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
